// ===== design/ihc_pkg.sv =====
// Shared types, constants and helper functions for the IPv4 header check block.
package ihc_pkg;

   localparam logic [3:0] IP_VERSION          = 4'b0100;
   localparam logic [3:0] MIN_HEADER_WORDS    = 4'd5;
   localparam logic [5:0] CHECKSUM_HIGH_INDEX = 6'd10;
   localparam logic [5:0] CHECKSUM_LOW_INDEX  = 6'd11;
   localparam logic [5:0] PROTOCOL_INDEX      = 6'd9;
   localparam logic [5:0] SOURCE_FIRST_INDEX  = 6'd12;
   localparam logic [5:0] SOURCE_LAST_INDEX   = 6'd15;
   localparam logic [5:0] DEST_FIRST_INDEX    = 6'd16;
   localparam logic [5:0] DEST_LAST_INDEX     = 6'd19;
   localparam logic [7:0] PROTO_ICMP          = 8'd1;
   localparam logic [7:0] PROTO_UDP           = 8'd17;

   typedef enum logic [2:0] {
      VERDICT_BAD_HEADER   = 3'd0,
      VERDICT_BAD_CHECKSUM = 3'd1,
      VERDICT_NOT_FOR_US   = 3'd2,
      VERDICT_ICMP         = 3'd3,
      VERDICT_UDP          = 3'd4,
      VERDICT_UNREACHABLE  = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       packet_first;
   } beat_type;

   typedef struct packed {
      verdict_type verdict;
      logic [31:0] source_address;
      logic [5:0]  header_bytes;
      logic [7:0]  protocol_number;
   } result_type;

   // 16-bit ones-complement add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] t;
      s = {1'b0, a} + {1'b0, b};
      t = {1'b0, s[15:0]} + {16'd0, s[16]};
      return t[15:0];
   endfunction

endpackage

// ===== design/ihc_req_if.sv =====
// Byte input channel: valid/ready handshake carrying one packet byte per beat.
interface ihc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       packet_first;

   modport source (output valid, output packet_byte, output packet_first, input ready);
   modport sink   (input valid, input packet_byte, input packet_first, output ready);
endinterface

// ===== design/ihc_rsp_if.sv =====
// Verdict output channel: valid/ready handshake carrying one verdict per beat.
interface ihc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [31:0] source_address;
   logic [5:0]  header_bytes;
   logic [7:0]  protocol_number;

   modport source (output valid, output verdict, output source_address,
                   output header_bytes, output protocol_number, input ready);
   modport sink   (input valid, input verdict, input source_address,
                   input header_bytes, input protocol_number, output ready);
endinterface

// ===== design/ihc_input_stage.sv =====
// Input register: captures one byte beat and holds it until the header unit takes it.
module ihc_input_stage (
   input  logic               clock,
   input  logic               reset,
   ihc_req_if.sink            req_chan,
   input  logic               advance,
   output logic               beat_valid,
   output ihc_pkg::beat_type  beat
);
   import ihc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;
   logic     load;

   assign req_chan.ready = !valid_ff || advance;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= '{packet_byte: req_chan.packet_byte, packet_first: req_chan.packet_first};
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;
endmodule

// ===== design/ihc_header_unit.sv =====
// Header walker: per-byte checksum, field capture and verdict selection.
module ihc_header_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  ihc_pkg::beat_type   beat,
   input  logic [31:0]         local_address,
   output logic                result_valid,
   output ihc_pkg::result_type result
);
   import ihc_pkg::*;

   logic [5:0]  byte_index_ff, byte_index_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  high_byte_hold_ff, high_byte_hold_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [15:0] received_checksum_ff, received_checksum_in;
   logic [31:0] sender_address_ff, sender_address_in;
   logic [31:0] target_address_ff, target_address_in;
   logic [7:0]  protocol_hold_ff, protocol_hold_in;
   logic        packet_done_ff, packet_done_in;

   logic [5:0]  idx_cur;
   logic [15:0] sum_cur;
   logic        done_cur;
   logic [3:0]  words_cur;
   logic [15:0] word;
   logic [5:0]  last_index;
   logic [7:0]  b;

   always_comb begin
      b                    = beat.packet_byte;
      idx_cur              = beat.packet_first ? 6'd0 : byte_index_ff;
      sum_cur              = beat.packet_first ? 16'd0 : running_sum_ff;
      done_cur             = beat.packet_first ? 1'b0 : packet_done_ff;
      words_cur            = (idx_cur == 6'd0) ? b[3:0] : header_words_ff;
      last_index           = {words_cur, 2'b00} - 6'd1;
      word                 = {high_byte_hold_ff, b};

      byte_index_in        = byte_index_ff;
      running_sum_in       = running_sum_ff;
      high_byte_hold_in    = high_byte_hold_ff;
      header_words_in      = header_words_ff;
      received_checksum_in = received_checksum_ff;
      sender_address_in    = sender_address_ff;
      target_address_in    = target_address_ff;
      protocol_hold_in     = protocol_hold_ff;
      packet_done_in       = packet_done_ff;

      result_valid         = 1'b0;
      result               = '{verdict: VERDICT_BAD_HEADER, source_address: 32'd0,
                               header_bytes: {words_cur, 2'b00}, protocol_number: 8'd0};

      if (take) begin
         byte_index_in  = idx_cur;
         running_sum_in = sum_cur;
         packet_done_in = done_cur;
         if (!done_cur) begin
            if (idx_cur == 6'd0) begin
               header_words_in = words_cur;
            end
            if (idx_cur == 6'd0 && (b[7:4] != IP_VERSION || words_cur < MIN_HEADER_WORDS)) begin
               packet_done_in = 1'b1;
               result_valid   = 1'b1;
            end else begin
               if (!idx_cur[0]) begin
                  high_byte_hold_in = b;
               end else begin
                  if (idx_cur == CHECKSUM_LOW_INDEX) begin
                     received_checksum_in = word;
                     word                 = 16'd0;
                  end
                  running_sum_in = ones_add(sum_cur, word);
               end
               if (idx_cur == PROTOCOL_INDEX) begin
                  protocol_hold_in = b;
               end
               if (idx_cur >= SOURCE_FIRST_INDEX && idx_cur <= SOURCE_LAST_INDEX) begin
                  sender_address_in = {sender_address_ff[23:0], b};
               end
               if (idx_cur >= DEST_FIRST_INDEX && idx_cur <= DEST_LAST_INDEX) begin
                  target_address_in = {target_address_ff[23:0], b};
               end
               if (idx_cur == last_index) begin
                  packet_done_in         = 1'b1;
                  result_valid           = 1'b1;
                  result.source_address  = sender_address_in;
                  result.protocol_number = protocol_hold_in;
                  priority if (~running_sum_in != received_checksum_in) begin
                     result.verdict = VERDICT_BAD_CHECKSUM;
                  end else if (target_address_in != local_address) begin
                     result.verdict = VERDICT_NOT_FOR_US;
                  end else if (protocol_hold_in == PROTO_ICMP) begin
                     result.verdict = VERDICT_ICMP;
                  end else if (protocol_hold_in == PROTO_UDP) begin
                     result.verdict = VERDICT_UDP;
                  end else begin
                     result.verdict = VERDICT_UNREACHABLE;
                  end
               end else begin
                  byte_index_in = idx_cur + 6'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= 6'd0;
         running_sum_ff <= 16'd0;
         packet_done_ff <= 1'b1;
      end else begin
         byte_index_ff  <= byte_index_in;
         running_sum_ff <= running_sum_in;
         packet_done_ff <= packet_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_byte_hold_ff    <= 8'd0;
         header_words_ff      <= 4'd0;
         received_checksum_ff <= 16'd0;
         sender_address_ff    <= 32'd0;
         target_address_ff    <= 32'd0;
         protocol_hold_ff     <= 8'd0;
      end else begin
         high_byte_hold_ff    <= high_byte_hold_in;
         header_words_ff      <= header_words_in;
         received_checksum_ff <= received_checksum_in;
         sender_address_ff    <= sender_address_in;
         target_address_ff    <= target_address_in;
         protocol_hold_ff     <= protocol_hold_in;
      end
   end
endmodule

// ===== design/ihc_result_stage.sv =====
// Result register: holds a verdict beat until the consumer takes it.
module ihc_result_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                result_valid,
   input  ihc_pkg::result_type result,
   output logic                advance,
   ihc_rsp_if.source           rsp_chan
);
   import ihc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign advance  = !valid_ff || rsp_chan.ready;
   assign valid_in = advance ? result_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.verdict         = result_ff.verdict;
   assign rsp_chan.source_address  = result_ff.source_address;
   assign rsp_chan.header_bytes    = result_ff.header_bytes;
   assign rsp_chan.protocol_number = result_ff.protocol_number;
endmodule

// ===== design/ipv4_header_check_classify.sv =====
// IPv4 receive header check and classifier, top level.
// Throughput: one packet byte per cycle, sustained whatever the verdict pattern while the
//   consumer keeps rsp_chan ready high.
// A verdict passes the input register, which holds the byte that decides it, and then the
//   result register, which drives rsp_chan; it can be taken while rsp_chan ready is high.
// While a verdict waits, one more byte enters the input register, then the input stalls.
// Reset (synchronous, active high): both stages empty, local address zero, walker idle
//   until a byte marked first arrives.
module ipv4_header_check_classify (
   input  logic        clock,
   input  logic        reset,
   ihc_req_if.sink     req_chan,
   ihc_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import ihc_pkg::*;

   logic        beat_valid;
   beat_type    beat;
   logic        advance;
   logic        take;
   logic        result_valid;
   result_type  result;
   logic [31:0] local_address_ff;
   logic [31:0] local_address_in;

   // Local address register: the user must write it only while the block is idle; the block does not enforce this
   assign local_address_in = csr_write_enable ? csr_write_data : local_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= 32'd0;
      end else begin
         local_address_ff <= local_address_in;
      end
   end

   // Hold the byte beat until the result side can accept whatever it causes
   ihc_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   // Consume the held beat whenever the result register is free or draining
   assign take = beat_valid && advance;

   // Walk the header: checksum, capture fields, pick the verdict
   ihc_header_unit u_header_unit (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .beat          (beat),
      .local_address (local_address_ff),
      .result_valid  (result_valid),
      .result        (result)
   );

   // Register the verdict towards the consumer
   ihc_result_stage u_result_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .advance      (advance),
      .rsp_chan     (rsp_chan)
   );

   // A bad header verdict never carries address or protocol
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.verdict == VERDICT_BAD_HEADER
      |-> rsp_chan.source_address == 32'd0 && rsp_chan.protocol_number == 8'd0)
      else $error("bad header verdict carries captured fields");

   // A verdict past the header check always covers at least a minimum header
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.verdict != VERDICT_BAD_HEADER
      |-> rsp_chan.header_bytes >= 6'd20)
      else $error("classified verdict with short header");

   // A held beat that cannot advance stays put
   assert property (@(posedge clock) disable iff (reset)
      beat_valid && !advance |=> beat_valid && $stable(beat))
      else $error("input beat lost while stalled");
endmodule

// ===== tb/ipv4_header_check_classify_checker.sv =====
`timescale 1ns / 100ps
// Checker for the IPv4 header check block: tracks packet bytes, predicts verdicts, compares them.
module ipv4_header_check_classify_checker (
   input  logic        clock,
   input  logic        reset,
   ihc_req_if          req_mon,
   ihc_rsp_if          rsp_mon,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output int unsigned mismatch_count,
   output int unsigned verdicts_pending
);
   import ihc_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   logic [31:0] local_address;
   logic [5:0]  walk_index;
   logic [15:0] header_sum;
   logic [7:0]  upper_byte;
   logic [3:0]  ihl_words;
   logic [15:0] stated_checksum;
   logic [31:0] source_addr;
   logic [31:0] dest_addr;
   logic [7:0]  protocol_seen;
   logic        walker_idle;

   result_type verdicts_due[$];

   function automatic logic [15:0] end_around_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // Restart the header walk; the block does the same on every byte marked first.
   function automatic void clear_walker();
      walk_index      = '0;
      header_sum      = '0;
      upper_byte      = '0;
      ihl_words       = '0;
      stated_checksum = '0;
      source_addr     = '0;
      dest_addr       = '0;
      protocol_seen   = '0;
   endfunction

   // Advance the walk by one byte; return 1 with the verdict when this byte decides one.
   function automatic bit classify_byte(input logic [7:0] value, input logic first,
                                        output result_type verdict_out);
      logic [5:0]  at;
      logic [5:0]  last_index;
      logic [15:0] word;
      verdict_out = '0;
      if (first) begin
         clear_walker();
         walker_idle = 1'b0;
      end
      if (walker_idle) return 1'b0;

      at = walk_index;
      if (at == 6'd0) begin
         ihl_words = value[3:0];
         if (value[7:4] != IP_VERSION || ihl_words < MIN_HEADER_WORDS) begin
            walker_idle = 1'b1;
            verdict_out.verdict      = VERDICT_BAD_HEADER;
            verdict_out.header_bytes = {ihl_words, 2'b00};
            return 1'b1;
         end
      end

      if (!at[0]) begin
         upper_byte = value;
      end else begin
         word = {upper_byte, value};
         // checksum field counts as zero in the sum
         if (at == CHECKSUM_LOW_INDEX) begin
            stated_checksum = word;
            word = '0;
         end
         header_sum = end_around_add(header_sum, word);
      end

      if (at == PROTOCOL_INDEX) protocol_seen = value;
      if (at >= SOURCE_FIRST_INDEX && at <= SOURCE_LAST_INDEX)
         source_addr = {source_addr[23:0], value};
      if (at >= DEST_FIRST_INDEX && at <= DEST_LAST_INDEX)
         dest_addr = {dest_addr[23:0], value};

      last_index = {ihl_words, 2'b00} - 6'd1;
      if (at == last_index) begin
         walker_idle = 1'b1;
         if (~header_sum != stated_checksum)
            verdict_out.verdict = VERDICT_BAD_CHECKSUM;
         else if (dest_addr != local_address)
            verdict_out.verdict = VERDICT_NOT_FOR_US;
         else if (protocol_seen == PROTO_ICMP)
            verdict_out.verdict = VERDICT_ICMP;
         else if (protocol_seen == PROTO_UDP)
            verdict_out.verdict = VERDICT_UDP;
         else
            verdict_out.verdict = VERDICT_UNREACHABLE;
         verdict_out.source_address  = source_addr;
         verdict_out.header_bytes    = {ihl_words, 2'b00};
         verdict_out.protocol_number = protocol_seen;
         return 1'b1;
      end

      walk_index = at + 6'd1;
      return 1'b0;
   endfunction

   task automatic note_mismatch(input string what, input result_type want, input result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display({"%0t verdict mismatch (%s): expected v=%0d src=%h hdr=%0d proto=%0d,",
                   " got v=%0d src=%h hdr=%0d proto=%0d"},
                  $realtime, what, want.verdict, want.source_address, want.header_bytes,
                  want.protocol_number, got.verdict, got.source_address, got.header_bytes,
                  got.protocol_number);
   endtask

   always @(posedge clock) begin
      result_type predicted;
      result_type expected;
      result_type observed;
      if (reset) begin
         local_address = '0;
         clear_walker();
         walker_idle = 1'b1;
         verdicts_due.delete();
      end else begin
         if (csr_write_enable) local_address = csr_write_data;

         if (req_mon.valid && req_mon.ready)
            if (classify_byte(req_mon.packet_byte, req_mon.packet_first, predicted))
               verdicts_due.push_back(predicted);

         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.verdict         = verdict_type'(rsp_mon.verdict);
            observed.source_address  = rsp_mon.source_address;
            observed.header_bytes    = rsp_mon.header_bytes;
            observed.protocol_number = rsp_mon.protocol_number;
            if (verdicts_due.size() == 0) begin
               note_mismatch("no verdict due", '0, observed);
            end else begin
               expected = verdicts_due.pop_front();
               if (observed.verdict !== expected.verdict ||
                   observed.source_address !== expected.source_address ||
                   observed.header_bytes !== expected.header_bytes ||
                   observed.protocol_number !== expected.protocol_number)
                  note_mismatch("field", expected, observed);
            end
         end
      end
      verdicts_pending = verdicts_due.size();
   end

endmodule

// ===== tb/ipv4_header_check_classify_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives packet bytes and the local address into the header check block.
module ipv4_header_check_classify_tb;
   import ihc_pkg::*;

   localparam int unsigned CYCLE_LIMIT         = 1_000_000;
   localparam int unsigned RANDOM_HEADER_BEATS = 1460;
   localparam int unsigned RANDOM_PHASES       = 4;
   localparam int unsigned SETTLE_CYCLES       = 6;
   localparam int unsigned DRAIN_CYCLES        = 10;
   localparam int unsigned HOLD_OFF_CYCLES     = 400;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   ihc_req_if req_chan();
   ihc_rsp_if rsp_chan();

   int unsigned mismatch_count;
   int unsigned verdicts_pending;
   int unsigned header_beats;     // beats that walk a header, ignored bytes left out
   int unsigned cycle_count;

   logic [7:0]  pkt[$];           // packet under construction, wire order
   int unsigned header_len;
   logic [31:0] local_addr_shadow;

   bit tx_burst;                  // sender offers back to back
   bit rx_burst;                  // receiver takes every verdict at once
   bit hold_off_request;          // ask the receiver for one long stall

   ipv4_header_check_classify DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ipv4_header_check_classify_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none at all in a burst.
   function automatic int unsigned pick_gap(input bit burst);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one beat after a random gap and hold it until the block takes it.
   // Valid stays high on return so that the next beat can follow without a bubble.
   task automatic send_beat(input logic [7:0] value, input logic first, input bit counted);
      repeat (pick_gap(tx_burst)) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.packet_byte  <= value;
      req_chan.packet_first <= first;
      do @(posedge clock); while (!req_chan.ready);
      if (counted) header_beats++;
   endtask

   // Assemble a header with a correct checksum, then optionally spoil one bit of it.
   // Byte 0 is never spoiled, so the version and length still pass.
   task automatic build_header(input logic [3:0] ihl, input logic [7:0] proto,
                               input logic [31:0] src, input logic [31:0] dst,
                               input bit corrupt, input int unsigned payload_len);
      logic [31:0] acc;
      logic [15:0] csum;
      int unsigned flip_at;
      pkt.delete();
      header_len = ihl * 4;
      pkt.push_back({IP_VERSION, ihl});
      repeat (8) pkt.push_back(8'($urandom));   // service type, length, id, fragment, ttl
      pkt.push_back(proto);
      pkt.push_back(8'h00);                     // checksum, filled in below
      pkt.push_back(8'h00);
      for (int i = 3; i >= 0; i--) pkt.push_back(src[i*8 +: 8]);
      for (int i = 3; i >= 0; i--) pkt.push_back(dst[i*8 +: 8]);
      while (pkt.size() < header_len) pkt.push_back(8'($urandom));   // options
      acc = '0;
      for (int i = 0; i < header_len; i += 2) acc += {16'd0, pkt[i], pkt[i+1]};
      while (acc[31:16] != 16'd0) acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      csum    = ~acc[15:0];
      pkt[10] = csum[15:8];
      pkt[11] = csum[7:0];
      if (corrupt) begin
         flip_at = $urandom_range(1, header_len - 1);
         pkt[flip_at] = pkt[flip_at] ^ (8'd1 << $urandom_range(0, 7));
      end
      repeat (payload_len) pkt.push_back(8'($urandom));
   endtask

   // Send the first upto bytes of the packet; payload beats are not counted.
   task automatic send_packet(input int unsigned upto);
      for (int unsigned i = 0; i < upto; i++) send_beat(pkt[i], i == 0, i < header_len);
   endtask

   task automatic send_header_packet(input logic [3:0] ihl, input logic [7:0] proto,
                                     input logic [31:0] src, input logic [31:0] dst,
                                     input bit corrupt, input int unsigned payload_len);
      build_header(ihl, proto, src, dst, corrupt, payload_len);
      send_packet(pkt.size());
   endtask

   // Write the local address with the block idle: drop valid, wait for every verdict,
   // then let any payload beat still in the pipe drain.
   task automatic write_local_address(input logic [31:0] value);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (verdicts_pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      local_addr_shadow = value;
   endtask

   // One random packet: mostly well formed, some with a spoilt checksum, some with a bad
   // first byte, some cut short mid-header, and a little stray noise.
   task automatic send_random_packet();
      int unsigned kind;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      logic [31:0] dst;
      logic [7:0]  lead;
      kind     = $urandom_range(0, 99);
      tx_burst = ($urandom_range(0, 3) == 0);
      ihl      = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(6, 15));
      case ($urandom_range(0, 3))
         0: begin
            proto = PROTO_ICMP;
         end
         1: begin
            proto = PROTO_UDP;
         end
         default: begin
            proto = 8'($urandom);
         end
      endcase
      dst = ($urandom_range(0, 4) != 0) ? local_addr_shadow : $urandom;
      if (kind < 75) begin
         send_header_packet(ihl, proto, $urandom, dst, kind >= 60, $urandom_range(0, 6));
      end else if (kind < 85) begin
         // force a rejected first byte: wrong version, or version 4 with a short length
         lead = 8'($urandom);
         if (lead[7:4] == IP_VERSION) lead[3:0] = 4'($urandom_range(0, 4));
         send_beat(lead, 1'b1, 1'b1);
         repeat ($urandom_range(0, 3)) send_beat(8'($urandom), 1'b0, 1'b0);
      end else if (kind < 95) begin
         build_header(ihl, proto, $urandom, dst, 1'b0, 0);
         send_packet($urandom_range(1, header_len - 1));
      end else begin
         repeat ($urandom_range(1, 4)) send_beat(8'($urandom), 1'b0, 1'b0);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request while bytes keep coming.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            repeat (HOLD_OFF_CYCLES) begin
               @(negedge clock);
               rsp_chan.ready <= 1'b0;
            end
         end
         repeat (pick_gap(rx_burst)) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
      end
   end

   // Switch the receiver between stalling and taking everything, in stretches.
   initial begin
      rx_burst = 1'b0;
      forever begin
         repeat ($urandom_range(50, 400)) @(posedge clock);
         rx_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // Watchdog: give up once the run takes far longer than any correct one could.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ipv4_header_check_classify_tb: done, errors");
      $finish;
   end

   initial begin
      int unsigned phase_end;
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_write_data        = '0;
      req_chan.valid        = 1'b0;
      req_chan.packet_byte  = '0;
      req_chan.packet_first = 1'b0;
      tx_burst              = 1'b0;
      hold_off_request      = 1'b0;
      header_beats          = 0;
      local_addr_shadow     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed cases with the local address at zero.
      write_local_address(32'h0000_0000);
      send_beat(8'hFF, 1'b0, 1'b0);                // idle after reset: ignore
      send_beat(8'h35, 1'b1, 1'b1);                // wrong version
      send_beat(8'h44, 1'b1, 1'b1);                // header shorter than five words
      send_beat(8'h00, 1'b1, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
      send_beat(8'h45, 1'b0, 1'b0);                // rest of a dropped packet: ignore
      send_header_packet(4'd5, PROTO_ICMP, 32'hFFFF_FFFF, 32'h0, 1'b0, 0);
      send_header_packet(4'd5, PROTO_UDP, 32'h0000_0000, 32'h0, 1'b0, 2);
      send_header_packet(4'd5, 8'h00, $urandom, 32'h0, 1'b0, 0);
      send_header_packet(4'd5, 8'hFF, $urandom, 32'h0, 1'b0, 1);
      send_header_packet(4'd5, PROTO_ICMP, $urandom, 32'h0000_0001, 1'b0, 0);
      send_header_packet(4'd5, PROTO_UDP, $urandom, 32'h0, 1'b1, 0);
      // checksum outranks the address test
      send_header_packet(4'd5, PROTO_UDP, $urandom, 32'h8000_0000, 1'b1, 0);
      send_header_packet(4'd15, PROTO_UDP, $urandom, 32'h0, 1'b0, 3);
      // abandon a header part way through, then start afresh
      build_header(4'd5, PROTO_ICMP, $urandom, 32'h0, 1'b0, 0);
      send_packet(11);
      send_header_packet(4'd6, PROTO_ICMP, $urandom, 32'h0, 1'b0, 0);

      // Directed cases with the local address all ones.
      write_local_address(32'hFFFF_FFFF);
      send_header_packet(4'd5, PROTO_ICMP, 32'h0102_0304, 32'hFFFF_FFFF, 1'b0, 0);
      send_header_packet(4'd7, PROTO_UDP, $urandom, 32'hFFFF_FFFF, 1'b0, 0);
      send_header_packet(4'd5, 8'd6, $urandom, 32'h0000_0000, 1'b0, 0);

      // Random phases, each under a fresh local address; the first opens with a hold-off.
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_local_address($urandom);
         if (phase == 0) hold_off_request = 1'b1;
         phase_end = header_beats + RANDOM_HEADER_BEATS / RANDOM_PHASES;
         while (header_beats < phase_end) send_random_packet();
      end

      // Drain: drop valid, collect every verdict, then watch the idle block before reporting.
      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (verdicts_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ipv4_header_check_classify_tb: done, clean");
      else
         $display("ipv4_header_check_classify_tb: done, errors");
      $finish;
   end

endmodule
